// ===== src/bfsp_pkg.sv =====
// Shared types and codes for the Bellman-Ford shortest path block.
package bfsp_pkg;

   // Operation codes carried on the request tuser field.
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_RUN   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_VERTEX_COUNT = 1'b0;
   localparam logic CSR_SOURCE       = 1'b1;

   // Field widths fixed by the interface.
   localparam int VTX_W    = 5;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;
   localparam int VCNT_W   = 6;
   localparam int EDGE_W   = 2 * VTX_W + WEIGHT_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic run_start;  // latch vertex count, clear counters and cycle flag
      logic init;       // clear reached flags, seed the source vertex
      logic edge_latch; // capture the fetched edge
      logic sum;        // form the saturated candidate distance
      logic update;     // compare and relax (or check) the current edge
      logic emit_sel;   // distance read port follows the vertex counter
      logic vtx_next;   // step to the next vertex to report
   } bfsp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic edges_empty;
      logic last_edge;
      logic last_pass;
      logic last_vtx;
   } bfsp_status_type;

endpackage

// ===== src/bfsp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bfsp_ctrl.sv =====
// Sequencing state machine for loading edges, relaxation passes and result output.
module bfsp_ctrl import bfsp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [1:0]      req_op,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output bfsp_cmd_type    cmd,
   input  bfsp_status_type status
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT      = 4'd1;
   localparam logic [3:0] ST_FETCH     = 4'd2;
   localparam logic [3:0] ST_LATCH     = 4'd3;
   localparam logic [3:0] ST_LOOKUP    = 4'd4;
   localparam logic [3:0] ST_SUM       = 4'd5;
   localparam logic [3:0] ST_UPDATE    = 4'd6;
   localparam logic [3:0] ST_EMIT_RD   = 4'd7;
   localparam logic [3:0] ST_EMIT_HOLD = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT_HOLD);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   // Command decode.
   always_comb begin
      cmd            = '0;
      cmd.run_start  = req_fire && (req_op == OP_RUN);
      cmd.init       = (state_ff == ST_INIT);
      cmd.edge_latch = (state_ff == ST_LATCH);
      cmd.sum        = (state_ff == ST_SUM);
      cmd.update     = (state_ff == ST_UPDATE);
      cmd.emit_sel   = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_HOLD);
      cmd.vtx_next   = rsp_fire && !status.last_vtx;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_op == OP_RUN)) begin
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = status.edges_empty ? ST_EMIT_RD : ST_FETCH;
         end
         ST_FETCH:  state_in = ST_LATCH;
         ST_LATCH:  state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_SUM;
         ST_SUM:    state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (status.last_edge && status.last_pass) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_HOLD;
         ST_EMIT_HOLD: begin
            if (rsp_fire) begin
               state_in = status.last_vtx ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/bfsp_dpath.sv =====
// Edge store, distance stores, reached flags, counters and relaxation arithmetic.
module bfsp_dpath import bfsp_pkg::*; #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_fire,
   input  logic                       csr_index,
   input  logic [VCNT_W-1:0]          csr_data,
   input  logic                       req_fire,
   input  logic [1:0]                 req_op,
   input  logic [VTX_W-1:0]           edge_from,
   input  logic [VTX_W-1:0]           edge_to,
   input  logic signed [WEIGHT_W-1:0] edge_weight,
   input  bfsp_cmd_type               cmd,
   output bfsp_status_type            status,
   output logic [VTX_W-1:0]           vertex_index,
   output logic signed [DIST_W-1:0]   distance,
   output logic                       reachable,
   output logic                       negative_cycle,
   output logic                       last_vertex
);

   localparam int VAW = $clog2(MAX_VERTICES);
   localparam int NVW = $clog2(MAX_VERTICES + 1);
   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ETW = $clog2(MAX_EDGES + 1);

   // Configuration and bookkeeping registers.
   logic [VCNT_W-1:0]       vertex_count_ff;
   logic [VTX_W-1:0]        source_ff;
   logic [ETW-1:0]          edge_total_ff;
   logic [NVW-1:0]          nv_ff;
   logic [NVW-1:0]          pass_ff;
   logic [EAW-1:0]          edge_idx_ff;
   logic [VAW-1:0]          vtx_ff;
   logic                    cycle_ff;
   logic [MAX_VERTICES-1:0] reach_ff;

   // Current edge registers.
   logic [VAW-1:0]             from_ff;
   logic [VAW-1:0]             to_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;
   logic                       edge_ok_ff;
   logic signed [DIST_W-1:0]   cand_ff;
   logic signed [DIST_W-1:0]   cand_in;
   logic signed [DIST_W-1:0]   dist_to_ff;

   logic [NVW-1:0]    nv_run;
   logic [8:0]        vc_wide;
   logic              source_ok;
   logic              edge_wr;
   logic [EDGE_W-1:0] edge_rd;
   logic [VTX_W-1:0]  rd_from;
   logic [VTX_W-1:0]  rd_to;
   logic [DIST_W:0]   sum;
   logic              reach_from;
   logic              reach_to;
   logic              relax;
   logic              apply;
   logic              dist_wr;
   logic [VAW-1:0]    dist_waddr;
   logic [DIST_W-1:0] dist_wdata;
   logic [VAW-1:0]    raddr_a;
   logic [DIST_W-1:0] rdata_a;
   logic [DIST_W-1:0] rdata_b;

   // Vertex count in use: zero acts as one, large values stop at the capacity.
   assign vc_wide = 9'(vertex_count_ff);
   assign nv_run  = (vertex_count_ff == '0) ? NVW'(1) :
                    (vc_wide > 9'(MAX_VERTICES)) ? NVW'(MAX_VERTICES) :
                    NVW'(vertex_count_ff);
   assign source_ok = 9'(source_ff) < 9'(nv_ff);

   // Edge memory: appended on add items, walked during a run.
   assign edge_wr = req_fire && (req_op == OP_ADD) && (edge_total_ff < ETW'(MAX_EDGES));

   bfsp_ram #(
      .WIDTH(EDGE_W),
      .DEPTH(MAX_EDGES)
   ) u_edge_ram (
      .clock  (clock),
      .wr_en  (edge_wr),
      .wr_addr(EAW'(edge_total_ff)),
      .wr_data({edge_weight, edge_to, edge_from}),
      .rd_addr(edge_idx_ff),
      .rd_data(edge_rd)
   );

   assign rd_from = edge_rd[VTX_W-1:0];
   assign rd_to   = edge_rd[2*VTX_W-1:VTX_W];

   // Two copies of the distance store give the start and end reads together.
   assign raddr_a    = cmd.emit_sel ? vtx_ff : from_ff;
   assign dist_waddr = cmd.init ? VAW'(source_ff) : to_ff;
   assign dist_wdata = cmd.init ? '0 : cand_ff;
   assign dist_wr    = (cmd.init && source_ok) || (cmd.update && apply);

   bfsp_ram #(
      .WIDTH(DIST_W),
      .DEPTH(MAX_VERTICES)
   ) u_dist_ram_a (
      .clock  (clock),
      .wr_en  (dist_wr),
      .wr_addr(dist_waddr),
      .wr_data(dist_wdata),
      .rd_addr(raddr_a),
      .rd_data(rdata_a)
   );

   bfsp_ram #(
      .WIDTH(DIST_W),
      .DEPTH(MAX_VERTICES)
   ) u_dist_ram_b (
      .clock  (clock),
      .wr_en  (dist_wr),
      .wr_addr(dist_waddr),
      .wr_data(dist_wdata),
      .rd_addr(to_ff),
      .rd_data(rdata_b)
   );

   // Candidate distance, saturated to the signed 32-bit range.
   always_comb begin
      sum = {rdata_a[DIST_W-1], rdata_a} +
            {{(DIST_W + 1 - WEIGHT_W){weight_ff[WEIGHT_W-1]}}, weight_ff};
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand_in = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         cand_in = sum[DIST_W-1:0];
      end
   end

   // Relaxation test on the current edge.
   assign reach_from = edge_ok_ff && reach_ff[from_ff];
   assign reach_to   = edge_ok_ff && reach_ff[to_ff];
   assign relax      = reach_from && (!reach_to || (cand_ff < dist_to_ff));
   assign apply      = relax && !status.last_pass;

   // Status toward the controller.
   assign status.edges_empty = (edge_total_ff == '0);
   assign status.last_edge   = (ETW'(edge_idx_ff) == edge_total_ff - ETW'(1));
   assign status.last_pass   = (pass_ff == nv_ff - NVW'(1));
   assign status.last_vtx    = (NVW'(vtx_ff) == nv_ff - NVW'(1));

   // Configuration registers and edge count.
   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCNT_W'(5);
         source_ff       <= '0;
         edge_total_ff   <= '0;
      end else begin
         if (csr_fire) begin
            if (csr_index == CSR_VERTEX_COUNT) begin
               vertex_count_ff <= csr_data;
            end else begin
               source_ff <= csr_data[VTX_W-1:0];
            end
         end
         if (req_fire && (req_op == OP_CLEAR)) begin
            edge_total_ff <= '0;
         end else if (edge_wr) begin
            edge_total_ff <= edge_total_ff + ETW'(1);
         end
      end
   end

   // Run counters, reached flags and the cycle flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff       <= NVW'(1);
         pass_ff     <= '0;
         edge_idx_ff <= '0;
         vtx_ff      <= '0;
         cycle_ff    <= 1'b0;
         reach_ff    <= '0;
      end else begin
         if (cmd.run_start) begin
            nv_ff       <= nv_run;
            pass_ff     <= '0;
            edge_idx_ff <= '0;
            vtx_ff      <= '0;
            cycle_ff    <= 1'b0;
         end
         // Only the source starts out reached, and only when it is in use.
         if (cmd.init) begin
            reach_ff <= source_ok ? (MAX_VERTICES'(1) << source_ff) : '0;
         end
         if (cmd.update) begin
            if (status.last_pass && relax) begin
               cycle_ff <= 1'b1;
            end
            if (apply) begin
               reach_ff[to_ff] <= 1'b1;
            end
            if (status.last_edge) begin
               edge_idx_ff <= '0;
               pass_ff     <= pass_ff + NVW'(1);
            end else begin
               edge_idx_ff <= edge_idx_ff + EAW'(1);
            end
         end
         if (cmd.vtx_next) begin
            vtx_ff <= vtx_ff + VAW'(1);
         end
      end
   end

   // Edge and candidate payload registers.
   always_ff @(posedge clock) begin
      if (cmd.edge_latch) begin
         from_ff    <= VAW'(rd_from);
         to_ff      <= VAW'(rd_to);
         weight_ff  <= edge_rd[EDGE_W-1:2*VTX_W];
         edge_ok_ff <= (9'(rd_from) < 9'(nv_ff)) && (9'(rd_to) < 9'(nv_ff));
      end
      if (cmd.sum) begin
         cand_ff    <= cand_in;
         dist_to_ff <= rdata_b;
      end
   end

   // Result fields for the vertex being reported.
   assign vertex_index   = VTX_W'(vtx_ff);
   assign reachable      = reach_ff[vtx_ff];
   assign distance       = reach_ff[vtx_ff] ? rdata_a : '0;
   assign negative_cycle = cycle_ff;
   assign last_vertex    = status.last_vtx;

endmodule

// ===== src/bellman_ford_shortest_paths.sv =====
// Bellman-Ford single-source shortest paths over a loaded edge list.
// Clear and add items are taken while the block is idle and may follow back to back.
// A run item walks every edge through the five-step fetch, latch, lookup, sum and update
// sequence in each pass of the search, then emits one result per vertex in use.
// Reset empties the edge list, sets vertex_count to 5 and source_vertex to 0.
// Distance stores need no clearing; reached flags are cleared at the start of each run.
module bellman_ford_shortest_paths import bfsp_pkg::*; #(
   parameter int MAX_VERTICES = 32,
   parameter int MAX_EDGES    = 256
) (
   input  logic        clock,
   input  logic        reset,
   // Request item stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // edge_from[4:0], edge_to[9:5], edge_weight[25:10], zero
   input  logic [1:0]  req_tuser,  // op[1:0]
   // Result item stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // vertex_index[4:0], distance[36:5], reachable[37],
                                   // negative_cycle[38], zero
   output logic        rsp_tlast,  // last_vertex
   // Configuration writes.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   bfsp_cmd_type               cmd;
   bfsp_status_type            status;
   logic                       req_fire;
   logic signed [WEIGHT_W-1:0] edge_weight;
   logic [VTX_W-1:0]           vertex_index;
   logic signed [DIST_W-1:0]   distance;
   logic                       reachable;
   logic                       negative_cycle;

   assign csr_ready   = 1'b1;
   assign req_fire    = req_tvalid && req_tready;
   assign edge_weight = req_tdata[25:10];

   bfsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_op    (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .status    (status)
   );

   bfsp_dpath #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_EDGES   (MAX_EDGES)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_fire      (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_fire      (req_fire),
      .req_op        (req_tuser),
      .edge_from     (req_tdata[4:0]),
      .edge_to       (req_tdata[9:5]),
      .edge_weight   (edge_weight),
      .cmd           (cmd),
      .status        (status),
      .vertex_index  (vertex_index),
      .distance      (distance),
      .reachable     (reachable),
      .negative_cycle(negative_cycle),
      .last_vertex   (rsp_tlast)
   );

   // Result packing, lowest field first.
   assign rsp_tdata = {1'b0, negative_cycle, reachable, distance, vertex_index};

   // A result is never offered while requests are being taken.
   assert property (@(posedge clock) disable iff (reset) rsp_tvalid |-> !req_tready)
      else $error("result offered while accepting requests");

   // An update always follows the sum step of the same edge.
   assert property (@(posedge clock) disable iff (reset) cmd.update |-> $past(cmd.sum))
      else $error("edge update without a preceding sum step");

   // A run item closes the request side on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == OP_RUN)) |=> !req_tready)
      else $error("request side still open after a run item");

   // Taking the final result of a run returns the block to idle.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not idle after the final result");

endmodule

// ===== verif/bellman_ford_shortest_paths_test.sv =====
// Self-checking testbench for the Bellman-Ford shortest path block.
`timescale 1ns / 1ps

module bellman_ford_shortest_paths_test import bfsp_pkg::*;;

   localparam int MAX_VERTICES = 32;
   localparam int MAX_EDGES = 256;
   localparam int RANDOM_ITEMS = 380;
   localparam int IDLE_PCT = 23;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam longint DIST_MAX = 64'sd2147483647;
   localparam longint DIST_MIN = -64'sd2147483648;

   typedef struct {
      logic [VTX_W-1:0] src;
      logic [VTX_W-1:0] dst;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_rec_type;

   typedef struct {
      logic [VTX_W-1:0] vertex_index;
      logic signed [DIST_W-1:0] distance;
      logic reachable;
      logic negative_cycle;
      logic last_vertex;
   } vertex_report_type;

   // Keeps its own copy of the edge list and registers, solves each search
   // item and holds the per-vertex reports still to come.
   class shortest_path_board_type;
      edge_rec_type edge_list[MAX_EDGES];
      int unsigned edge_count;
      logic [VCNT_W-1:0] vertex_count_reg;
      logic [VTX_W-1:0] source_reg;
      logic signed [DIST_W-1:0] best_distance[MAX_VERTICES];
      bit reached[MAX_VERTICES];
      vertex_report_type pending_reports[$];
      int errors;
      int runs;
      int cycle_runs;
      int reports_checked;

      function new();
         edge_count = 0;
         vertex_count_reg = 6'd5;
         source_reg = '0;
         errors = 0;
         runs = 0;
         cycle_runs = 0;
         reports_checked = 0;
      endfunction

      function void set_register(logic index, logic [VCNT_W-1:0] value);
         if (index == CSR_VERTEX_COUNT) begin
            vertex_count_reg = value;
         end else begin
            source_reg = value[VTX_W-1:0];
         end
      endfunction

      // Returns 1 when the edge lowers (or first reaches) its end vertex.
      function bit relax_edge(edge_rec_type e, int nv, bit apply);
         longint wide;
         logic signed [DIST_W-1:0] cand;
         if (e.src >= nv || e.dst >= nv) return 1'b0;
         if (!reached[e.src]) return 1'b0;
         wide = best_distance[e.src];
         wide = wide + e.weight;
         if (wide > DIST_MAX) begin
            cand = 32'sh7FFFFFFF;
         end else if (wide < DIST_MIN) begin
            cand = 32'sh80000000;
         end else begin
            cand = wide[DIST_W-1:0];
         end
         if (reached[e.dst] && cand >= best_distance[e.dst]) return 1'b0;
         if (apply) begin
            best_distance[e.dst] = cand;
            reached[e.dst] = 1'b1;
         end
         return 1'b1;
      endfunction

      function void solve_paths();
         int nv;
         bit cycle;
         vertex_report_type r;
         nv = vertex_count_reg;
         if (nv < 1) nv = 1;
         if (nv > MAX_VERTICES) nv = MAX_VERTICES;
         for (int v = 0; v < MAX_VERTICES; v++) begin
            best_distance[v] = '0;
            reached[v] = 1'b0;
         end
         if (source_reg < nv) reached[source_reg] = 1'b1;
         for (int pass = 0; pass + 1 < nv; pass++) begin
            for (int j = 0; j < edge_count; j++) void'(relax_edge(edge_list[j], nv, 1'b1));
         end
         // One more sweep: any edge that could still relax means a negative cycle.
         cycle = 1'b0;
         for (int j = 0; j < edge_count; j++) begin
            if (relax_edge(edge_list[j], nv, 1'b0)) cycle = 1'b1;
         end
         for (int v = 0; v < nv; v++) begin
            r.vertex_index = VTX_W'(v);
            r.distance = reached[v] ? best_distance[v] : '0;
            r.reachable = reached[v];
            r.negative_cycle = cycle;
            r.last_vertex = (v + 1 == nv);
            pending_reports.push_back(r);
         end
         runs++;
         if (cycle) cycle_runs++;
      endfunction

      function void note_request(logic [1:0] op, logic [31:0] data);
         case (op)
            OP_CLEAR: begin
               edge_count = 0;
            end
            OP_ADD: begin
               if (edge_count < MAX_EDGES) begin
                  edge_list[edge_count].src = data[4:0];
                  edge_list[edge_count].dst = data[9:5];
                  edge_list[edge_count].weight = data[25:10];
                  edge_count++;
               end
            end
            OP_RUN: begin
               solve_paths();
            end
            default: begin
            end
         endcase
      endfunction

      function void compare_field(string field, logic [VTX_W-1:0] vtx,
                                  logic signed [DIST_W-1:0] want,
                                  logic signed [DIST_W-1:0] got);
         if (got !== want) begin
            $display("%0t: vertex %0d %s expected %0d, got %0d", $time, vtx, field, want, got);
            errors++;
         end
      endfunction

      function void check_report(logic [39:0] data, logic last);
         vertex_report_type want;
         vertex_report_type got;
         got.vertex_index = data[4:0];
         got.distance = data[36:5];
         got.reachable = data[37];
         got.negative_cycle = data[38];
         got.last_vertex = last;
         if (pending_reports.size() == 0) begin
            $display("%0t: report for vertex %0d arrived with none expected", $time,
                     got.vertex_index);
            errors++;
            return;
         end
         want = pending_reports.pop_front();
         reports_checked++;
         compare_field("vertex_index", want.vertex_index, want.vertex_index, got.vertex_index);
         compare_field("distance", want.vertex_index, want.distance, got.distance);
         compare_field("reachable", want.vertex_index, want.reachable, got.reachable);
         compare_field("negative_cycle", want.vertex_index, want.negative_cycle,
                       got.negative_cycle);
         compare_field("last_vertex", want.vertex_index, want.last_vertex, got.last_vertex);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_CLEAR;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = CSR_VERTEX_COUNT;
   logic [5:0] csr_data = '0;

   int req_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;
   int rsp_hold_left = 0;
   shortest_path_board_type board = new();

   bellman_ford_shortest_paths #(
      .MAX_VERTICES(MAX_VERTICES),
      .MAX_EDGES(MAX_EDGES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Every handshake is observed at the rising edge.
   always @(posedge clock) begin
      if (csr_valid && csr_ready) board.set_register(csr_index, csr_data);
      if (req_tvalid && req_tready) board.note_request(req_tuser, req_tdata);
      if (rsp_tvalid && rsp_tready) board.check_report(rsp_tdata, rsp_tlast);
   end

   // Result side: random stalls, or a long hold-off when one is requested.
   // The hold-off counts only cycles in which a result is waiting.
   initial begin : rsp_side
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_tready <= 1'b0;
            if (rsp_tvalid) rsp_hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
   end

   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      int roll;
      int mag;
      roll = $urandom_range(99);
      mag = $urandom_range(0, 40);
      if (roll < 65) return WEIGHT_W'(mag);
      if (roll < 88) return WEIGHT_W'(-(mag % 13));
      return WEIGHT_W'($urandom);
   endfunction

   // Mostly endpoints in use; now and then any vertex at all.
   function automatic logic [VTX_W-1:0] pick_vertex(int nv);
      if ($urandom_range(99) < 85) return VTX_W'($urandom_range(0, nv - 1));
      return VTX_W'($urandom_range(0, 31));
   endfunction

   // Offers one item and returns once it has been accepted.
   task automatic send_item(logic [1:0] op, logic [VTX_W-1:0] src, logic [VTX_W-1:0] dst,
                            logic signed [WEIGHT_W-1:0] weight);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {6'b0, weight, dst, src};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run();
      send_item(OP_RUN, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
   endtask

   task automatic write_csr(logic index, logic [5:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering items and wait until every expected report is in.
   task automatic drain_reports();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (board.pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : main
      int phase;
      int random_items;
      int vcount;
      int nv;
      int n_edges;
      int roll;
      logic [5:0] src_value;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset settings with an empty list, then an unused op code.
      send_run();
      send_item(OP_UNUSED, 5'd31, 5'd31, -16'sd1);
      // Field extremes, endpoints out of range and a self loop.
      send_item(OP_ADD, 5'd0, 5'd1, 16'sd32767);
      send_item(OP_ADD, 5'd1, 5'd2, -16'sd32768);
      send_item(OP_ADD, 5'd2, 5'd3, 16'sd5);
      send_item(OP_ADD, 5'd31, 5'd0, 16'sd1);
      send_item(OP_ADD, 5'd3, 5'd31, 16'sd7);
      send_item(OP_ADD, 5'd4, 5'd4, 16'sd0);
      send_item(OP_ADD, 5'd3, 5'd4, -16'sd3);
      send_run();
      // A loop of total weight -4 reachable from the source.
      send_item(OP_CLEAR, 5'd0, 5'd0, 16'sd0);
      send_item(OP_ADD, 5'd0, 5'd1, 16'sd3);
      send_item(OP_ADD, 5'd1, 5'd2, -16'sd2);
      send_item(OP_ADD, 5'd2, 5'd1, -16'sd2);
      send_run();
      // Vertex count of zero acts as one.
      drain_reports();
      write_csr(CSR_VERTEX_COUNT, 6'd0);
      send_run();
      // Vertex count above the maximum, source at the top vertex.
      drain_reports();
      write_csr(CSR_VERTEX_COUNT, 6'd63);
      write_csr(CSR_SOURCE, 6'd31);
      send_run();
      // Source outside the vertices in use.
      drain_reports();
      write_csr(CSR_VERTEX_COUNT, 6'd3);
      write_csr(CSR_SOURCE, 6'd7);
      send_run();
      drain_reports();
      write_csr(CSR_VERTEX_COUNT, 6'd32);
      write_csr(CSR_SOURCE, 6'd0);
      send_run();
      drain_reports();

      // Random graphs: one overfilled list, one phase without idling and one
      // with a long result hold-off while items keep coming.
      phase = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS || phase <= 6) begin
         req_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         rsp_idle_pct = (phase == 4) ? 0 : IDLE_PCT;
         roll = $urandom_range(99);
         if (phase == 2) vcount = 2;
         else if (roll < 70) vcount = $urandom_range(2, 10);
         else if (roll < 78) vcount = 1;
         else if (roll < 84) vcount = 0;
         else if (roll < 90) vcount = $urandom_range(33, 63);
         else vcount = $urandom_range(11, 32);
         nv = (vcount < 1) ? 1 : (vcount > MAX_VERTICES) ? MAX_VERTICES : vcount;
         if ($urandom_range(99) < 85) src_value = 6'($urandom_range(0, nv - 1));
         else src_value = 6'($urandom);
         write_csr(CSR_VERTEX_COUNT, 6'(vcount));
         write_csr(CSR_SOURCE, src_value);

         if (phase == 2) n_edges = MAX_EDGES + 4;
         else if (nv >= 16) n_edges = $urandom_range(0, 8);
         else n_edges = $urandom_range(0, 20);

         send_item(OP_CLEAR, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
         random_items++;
         for (int k = 0; k < n_edges; k++) begin
            if ($urandom_range(99) < 5) begin
               send_item(OP_UNUSED, VTX_W'($urandom), VTX_W'($urandom), WEIGHT_W'($urandom));
            end
            send_item(OP_ADD, pick_vertex(nv), pick_vertex(nv), pick_weight());
            if (k < MAX_EDGES) random_items++;
         end
         if (phase == 6) rsp_hold_left = HOLD_CYCLES;
         send_run();
         random_items++;
         // Extend the same list and search again.
         if (phase == 6 || $urandom_range(1) == 1) begin
            n_edges = $urandom_range(1, 4);
            for (int k = 0; k < n_edges; k++) begin
               send_item(OP_ADD, pick_vertex(nv), pick_vertex(nv), pick_weight());
               random_items++;
            end
            send_run();
            random_items++;
         end
         drain_reports();
         phase++;
      end

      if (board.pending_reports.size() != 0) begin
         $display("%0t: %0d reports never arrived", $time, board.pending_reports.size());
         board.errors++;
      end
      $display("Ran %0d searches over %0d graph phases, %0d of them with a negative cycle.",
               board.runs, phase, board.cycle_runs);
      $display("Checked %0d vertex reports, including an overfilled edge list.",
               board.reports_checked);
      if (board.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== bellman_ford_shortest_paths.f =====
src/bfsp_pkg.sv
src/bfsp_ram.sv
src/bfsp_ctrl.sv
src/bfsp_dpath.sv
src/bellman_ford_shortest_paths.sv
verif/bellman_ford_shortest_paths_test.sv
